// ===== sv/sgpe_pkg.sv =====
// sgpe_pkg: shared types, constants and fixed-point helpers for the stiffened-gas
// property evaluator. No dependencies; used by every file in sv/.
package sgpe_pkg;

  localparam int FRAC_BITS = 24;
  localparam int MAX_DIMS = 3;
  // quotient bits of (|a| << 24) / |b| for a 64-bit |a|
  localparam int DIV_STEPS = 64 + FRAC_BITS;
  // root bits of floor(sqrt(arg << 24)) for arg below 2^63
  localparam int SQRT_STEPS = 44;

  localparam logic [63:0] FX_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] FX_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] FX_ONE = 64'h0000_0000_0100_0000;

  // register indexes
  localparam logic [1:0] CFG_GAMMA = 2'd0;
  localparam logic [1:0] CFG_CP = 2'd1;
  localparam logic [1:0] CFG_P0 = 2'd2;
  localparam logic [1:0] CFG_DIMS = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_DENSITY = 2'd1;
  localparam logic [1:0] ST_NEG_ROOT = 2'd2;
  localparam logic [1:0] ST_SAT = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic signed [63:0] density;
    logic signed [63:0] momentum_x;
    logic signed [63:0] momentum_y;
    logic signed [63:0] momentum_z;
    logic signed [63:0] energy_density;
    logic signed [63:0] temperature_in;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] pressure;
    logic signed [63:0] temperature_out;
    logic signed [63:0] internal_energy;
    logic signed [63:0] enthalpy;
    logic [62:0]        sound_speed;
    logic [1:0]         status;
  } out_item_t;

  // magnitude of a two's complement word, most negative value gives 2^63
  function automatic logic [63:0] fx_mag(logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // apply sign to a magnitude and saturate, result is {sat, value}
  function automatic logic [64:0] fx_pack(logic neg, logic hi_nz, logic [63:0] lo);
    if (neg) begin
      if (hi_nz || (lo > FX_MIN)) return {1'b1, FX_MIN};
      return {1'b0, 64'd0 - lo};
    end
    if (hi_nz || lo[63]) return {1'b1, FX_MAX};
    return {1'b0, lo};
  endfunction

endpackage

// ===== sv/sgpe_mul.sv =====
// sgpe_mul: pipelined signed Q40.24 multiplier lanes with saturation, three stages.
// Depends on sgpe_pkg; carries a sideband word alongside the lanes.
module sgpe_mul #(
  parameter int LANES = 1,
  parameter int SB_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [LANES-1:0][63:0] a_i,
  input  logic [LANES-1:0][63:0] b_i,
  input  logic [SB_W-1:0]        sb_i,
  output logic                   valid_o,
  output logic [LANES-1:0][63:0] prod_o,
  output logic [LANES-1:0]       sat_o,
  output logic [SB_W-1:0]        sb_o
);

  logic [2:0]                    v_q;
  logic [LANES-1:0][3:0][63:0]   pp_q;
  logic [LANES-1:0]              neg1_q;
  logic [LANES-1:0]              neg2_q;
  logic [LANES-1:0][127:0]       full_q;
  logic [LANES-1:0][63:0]        prod_q;
  logic [LANES-1:0]              sat_q;
  logic [SB_W-1:0]               sb1_q;
  logic [SB_W-1:0]               sb2_q;
  logic [SB_W-1:0]               sb3_q;
  logic [LANES-1:0][63:0]        ma;
  logic [LANES-1:0][63:0]        mb;

  // valid bits travel with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ma[l] = sgpe_pkg::fx_mag(a_i[l]);
      mb[l] = sgpe_pkg::fx_mag(b_i[l]);
    end
  end

  // partial products, then one wide sum, then shift and saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        pp_q[l][0] <= ma[l][31:0] * mb[l][31:0];
        pp_q[l][1] <= ma[l][31:0] * mb[l][63:32];
        pp_q[l][2] <= ma[l][63:32] * mb[l][31:0];
        pp_q[l][3] <= ma[l][63:32] * mb[l][63:32];
        neg1_q[l] <= a_i[l][63] ^ b_i[l][63];
        full_q[l] <= {pp_q[l][3], pp_q[l][0]} + {32'd0, pp_q[l][1], 32'd0}
                     + {32'd0, pp_q[l][2], 32'd0};
        neg2_q[l] <= neg1_q[l];
        {sat_q[l], prod_q[l]} <= sgpe_pkg::fx_pack(neg2_q[l], |full_q[l][127:88],
                                                   full_q[l][87:24]);
      end
      sb1_q <= sb_i;
      sb2_q <= sb1_q;
      sb3_q <= sb2_q;
    end
  end

  assign valid_o = v_q[2];
  assign prod_o = prod_q;
  assign sat_o = sat_q;
  assign sb_o = sb3_q;

endmodule

// ===== sv/sgpe_div.sv =====
// sgpe_div: pipelined signed Q40.24 divider lanes, one quotient bit per stage.
// Depends on sgpe_pkg; carries a sideband word alongside the lanes.
module sgpe_div #(
  parameter int LANES = 1,
  parameter int SB_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [LANES-1:0][63:0] num_i,
  input  logic [LANES-1:0][63:0] den_i,
  input  logic [SB_W-1:0]        sb_i,
  output logic                   valid_o,
  output logic [LANES-1:0][63:0] quo_o,
  output logic [LANES-1:0]       sat_o,
  output logic [SB_W-1:0]        sb_o
);

  localparam int Steps = sgpe_pkg::DIV_STEPS;

  logic [LANES-1:0][63:0]      rem_q   [Steps+1];
  logic [LANES-1:0][Steps-1:0] nq_q    [Steps+1];
  logic [LANES-1:0][63:0]      den_q   [Steps+1];
  logic [LANES-1:0]            neg_q   [Steps+1];
  logic [LANES-1:0]            apos_q  [Steps+1];
  logic [LANES-1:0]            azero_q [Steps+1];
  logic [LANES-1:0]            dzero_q [Steps+1];
  logic [SB_W-1:0]             sb_q    [Steps+1];
  logic [Steps:0]              v_q;
  logic                        vo_q;
  logic [LANES-1:0][63:0]      quo_q;
  logic [LANES-1:0]            sat_q;
  logic [SB_W-1:0]             sbo_q;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic logic [64+Steps-1:0] div_step(logic [63:0] rem,
                                                   logic [Steps-1:0] nq,
                                                   logic [63:0] den);
    logic [64:0] r2;
    logic [64:0] diff;
    logic        q;
    r2 = {rem, nq[Steps-1]};
    diff = r2 - {1'b0, den};
    q = (r2 >= {1'b0, den});
    return {(q ? diff[63:0] : r2[63:0]), nq[Steps-2:0], q};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v_q <= {v_q[Steps-1:0], valid_i};
      vo_q <= v_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // load: magnitudes and sign flags
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= '0;
        nq_q[0][l] <= {sgpe_pkg::fx_mag(num_i[l]), sgpe_pkg::FRAC_BITS'(0)};
        den_q[0][l] <= sgpe_pkg::fx_mag(den_i[l]);
        neg_q[0][l] <= num_i[l][63] ^ den_i[l][63];
        apos_q[0][l] <= !num_i[l][63] && (num_i[l] != '0);
        azero_q[0][l] <= (num_i[l] == '0);
        dzero_q[0][l] <= (den_i[l] == '0);
      end
      sb_q[0] <= sb_i;
      // quotient bit stages
      for (int s = 1; s <= Steps; s++) begin
        for (int l = 0; l < LANES; l++) begin
          {rem_q[s][l], nq_q[s][l]} <= div_step(rem_q[s-1][l], nq_q[s-1][l],
                                                den_q[s-1][l]);
        end
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
        apos_q[s] <= apos_q[s-1];
        azero_q[s] <= azero_q[s-1];
        dzero_q[s] <= dzero_q[s-1];
        sb_q[s] <= sb_q[s-1];
      end
      // sign and saturation, zero divisor gives the signed limit, or zero for a zero numerator
      for (int l = 0; l < LANES; l++) begin
        if (dzero_q[Steps][l]) begin
          sat_q[l] <= 1'b1;
          quo_q[l] <= apos_q[Steps][l] ? sgpe_pkg::FX_MAX :
                      (azero_q[Steps][l] ? 64'd0 : sgpe_pkg::FX_MIN);
        end else begin
          {sat_q[l], quo_q[l]} <= sgpe_pkg::fx_pack(neg_q[Steps][l],
                                                    |nq_q[Steps][l][Steps-1:64],
                                                    nq_q[Steps][l][63:0]);
        end
      end
      sbo_q <= sb_q[Steps];
    end
  end

  assign valid_o = vo_q;
  assign quo_o = quo_q;
  assign sat_o = sat_q;
  assign sb_o = sbo_q;

endmodule

// ===== sv/stiffened_gas_property_eval_top.sv =====
// stiffened_gas_property_eval_top: stiffened-gas equation of state, one cell per cycle unless stalled.
// Depends on sgpe_pkg, sgpe_mul and sgpe_div.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_item_i carries one cell: mode bit,
//   density, three momentum components, total energy density and a temperature,
//   all signed Q40.24. The output channel out_valid_o / out_stall_i / out_item_o
//   returns pressure, temperature, internal energy, enthalpy, sound speed and a
//   status code for each cell, in order. An item moves when valid is high and
//   stall is low.
//   One item is accepted every cycle while in_stall_o is low. The two long-division
//   chains (88 quotient bits each, one per stage) and the 44-stage square root set
//   the depth.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes gamma, Cp,
//   p0 and the dimension count; write only while the pipeline is empty.
//   Reset clears all valid bits and loads the default gas constants.
//   When the receiver stalls, a skid register takes one more item, then
//   in_stall_o rises and the whole pipeline holds until the output moves.
module stiffened_gas_property_eval_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sgpe_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sgpe_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [58:0]          cfg_data_i
);

  localparam int SqSteps = sgpe_pkg::SQRT_STEPS;

  typedef struct packed {
    logic        req;
    logic [63:0] rho;
    logic        sat_t;
  } p2_sb_t;

  typedef struct packed {
    logic        req;
    logic [63:0] rho;
    logic [63:0] er;
    logic [63:0] p0r;
    logic [63:0] tcpg;
    logic        sat_c;
    logic        sat_t;
  } p3_sb_t;

  typedef struct packed {
    logic        req;
    logic [63:0] rho;
    logic [63:0] er;
    logic [63:0] p0r;
    logic [63:0] tcpg;
    logic [63:0] grho;
    logic [63:0] gp0;
    logic [63:0] sq2;
    logic [63:0] s1;
    logic        sat_c;
    logic        sat_t;
  } g1_t;

  typedef struct packed {
    logic        req;
    logic [63:0] rho;
    logic [63:0] er;
    logic [63:0] p0r;
    logic [63:0] grho;
    logic [63:0] gp0;
    logic [63:0] ke;
    logic [63:0] et;
    logic        sat_c;
    logic        sat_t;
  } g2_t;

  typedef struct packed {
    logic        req;
    logic [63:0] rho;
    logic [63:0] p0r;
    logic [63:0] grho;
    logic [63:0] gp0;
    logic [63:0] een;
    logic [63:0] et;
    logic        sat_c;
    logic        sat_t;
  } g3_t;

  typedef struct packed {
    logic [63:0] rho;
    logic [63:0] grho;
    logic [63:0] gp0;
    logic [63:0] e;
    logic [63:0] d;
    logic        sat;
  } g4_t;

  typedef struct packed {
    logic [63:0] rho;
    logic [63:0] gp0;
    logic [63:0] e;
    logic        sat;
  } p4_sb_t;

  typedef struct packed {
    logic [63:0] rho;
    logic [63:0] e;
    logic [63:0] p;
    logic [63:0] tm;
    logic        sat;
  } g5_t;

  typedef struct packed {
    logic [63:0] rho;
    logic [63:0] e;
    logic [63:0] p;
    logic [63:0] sp;
    logic [63:0] tm;
    logic        sat;
  } g6_t;

  typedef struct packed {
    logic [63:0] rho;
    logic [63:0] e;
    logic [63:0] p;
    logic        sat;
  } p6_sb_t;

  typedef struct packed {
    logic [63:0] rho;
    logic [63:0] e;
    logic [63:0] p;
    logic [63:0] temp;
    logic [63:0] enth;
    logic        neg;
    logic        sat;
  } g7_t;

  // saturating add and subtract, result is {sat, value}
  function automatic logic [64:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return {1'b1, (s[64] ? sgpe_pkg::FX_MIN : sgpe_pkg::FX_MAX)};
    return {1'b0, s[63:0]};
  endfunction

  function automatic logic [64:0] sat_sub(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return {1'b1, (s[64] ? sgpe_pkg::FX_MIN : sgpe_pkg::FX_MAX)};
    return {1'b0, s[63:0]};
  endfunction

  // one square-root step: two radicand bits in, one root bit out
  function automatic logic [179:0] sqrt_step(logic [47:0] rem, logic [43:0] root,
                                             logic [87:0] v);
    logic [47:0] r2;
    logic [47:0] trial;
    logic        q;
    r2 = {rem[45:0], v[87:86]};
    trial = {2'b00, root, 2'b01};
    q = (r2 >= trial);
    return {(q ? (r2 - trial) : r2), root[42:0], q, v[85:0], 2'b00};
  endfunction

  // configuration registers
  logic [39:0] gam_q;
  logic [39:0] cp_q;
  logic [58:0] p0_q;
  logic [1:0]  dims_q;
  logic [1:0]  dims_eff;
  logic [sgpe_pkg::MAX_DIMS-1:0] use_dim;
  logic [63:0] gam64;
  logic [63:0] gam_m1;
  logic [63:0] cp64;
  logic [63:0] p064;

  // pipeline control and output side
  logic                en;
  logic                take;
  logic                out_v_q;
  logic                skid_v_q;
  sgpe_pkg::out_item_t out_q;
  sgpe_pkg::out_item_t skid_q;
  sgpe_pkg::out_item_t pipe_item;

  // phase signals
  logic                     p1_v;
  logic [63:0]              p1_prod;
  logic                     p1_sat;
  sgpe_pkg::in_item_t       p1_osb;
  logic [5:0][63:0]         p2_num;
  logic [5:0][63:0]         p2_den;
  p2_sb_t                   p2_isb;
  logic                     p2_v;
  logic [5:0][63:0]         p2_quo;
  logic [5:0]               p2_sat;
  p2_sb_t                   p2_osb;
  logic [4:0][63:0]         p3_a;
  logic [4:0][63:0]         p3_b;
  p3_sb_t                   p3_isb;
  logic                     p3_v;
  logic [4:0][63:0]         p3_prod;
  logic [4:0]               p3_sat;
  p3_sb_t                   p3_osb;
  g1_t                      g1_d;
  g1_t                      g1_q;
  g2_t                      g2_d;
  g2_t                      g2_q;
  g3_t                      g3_d;
  g3_t                      g3_q;
  g4_t                      g4_d;
  g4_t                      g4_q;
  logic                     g1_v_q;
  logic                     g2_v_q;
  logic                     g3_v_q;
  logic                     g4_v_q;
  logic [2:0][63:0]         sqm;
  logic [64:0]              s1r;
  logic [64:0]              kes;
  logic [64:0]              ets;
  logic [64:0]              eens;
  logic [64:0]              ds;
  p4_sb_t                   p4_isb;
  logic                     p4_v;
  logic [1:0][63:0]         p4_prod;
  logic [1:0]               p4_sat;
  p4_sb_t                   p4_osb;
  g5_t                      g5_d;
  g5_t                      g5_q;
  g6_t                      g6_d;
  g6_t                      g6_q;
  logic                     g5_v_q;
  logic                     g6_v_q;
  logic [64:0]              ps;
  logic [64:0]              sps;
  g5_t                      p5_isb;
  logic                     p5_v;
  logic [63:0]              p5_prod;
  logic                     p5_sat;
  g5_t                      p5_osb;
  logic [2:0][63:0]         p6_num;
  logic [2:0][63:0]         p6_den;
  p6_sb_t                   p6_isb;
  logic                     p6_v;
  logic [2:0][63:0]         p6_quo;
  logic [2:0]               p6_sat;
  p6_sb_t                   p6_osb;
  g7_t                      g7_d;
  logic [64:0]              enths;

  // square-root stages
  logic [47:0] sr_rem_q  [SqSteps+1];
  logic [43:0] sr_root_q [SqSteps+1];
  logic [87:0] sr_rad_q  [SqSteps+1];
  g7_t         sr_sb_q   [SqSteps+1];
  logic [SqSteps:0] sr_v_q;
  g7_t         last;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gam_q <= 40'd32413581;
      cp_q <= 40'd135812905697;
      p0_q <= 59'd19537068032000000;
      dims_q <= 2'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgpe_pkg::CFG_GAMMA: gam_q <= cfg_data_i[39:0];
        sgpe_pkg::CFG_CP:    cp_q <= cfg_data_i[39:0];
        sgpe_pkg::CFG_P0:    p0_q <= cfg_data_i;
        sgpe_pkg::CFG_DIMS:  dims_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // derived constants of the gas
  always_comb begin
    dims_eff = (dims_q > 2'(sgpe_pkg::MAX_DIMS)) ? 2'(sgpe_pkg::MAX_DIMS) : dims_q;
    for (int d = 0; d < sgpe_pkg::MAX_DIMS; d++) begin
      use_dim[d] = (2'(d) < dims_eff);
    end
  end

  assign gam64 = {24'd0, gam_q};
  assign gam_m1 = gam64 - sgpe_pkg::FX_ONE;
  assign cp64 = {24'd0, cp_q};
  assign p064 = {5'd0, p0_q};

  // whole pipeline holds while the skid register is full
  assign en = ~skid_v_q;
  assign in_stall_o = skid_v_q;

  // temperature times Cp
  sgpe_mul #(
    .LANES(1),
    .SB_W($bits(sgpe_pkg::in_item_t))
  ) u_mul_tcp (
    .clk_i,
    .rst_ni,
    .en_i(en),
    .valid_i(in_valid_i),
    .a_i(in_item_i.temperature_in),
    .b_i(cp64),
    .sb_i(in_item_i),
    .valid_o(p1_v),
    .prod_o(p1_prod),
    .sat_o(p1_sat),
    .sb_o(p1_osb)
  );

  // velocities, energy over density, p0 over density, temperature term over gamma
  assign p2_num = {p1_prod, p064, p1_osb.energy_density, p1_osb.momentum_z,
                   p1_osb.momentum_y, p1_osb.momentum_x};
  assign p2_den = {gam64, p1_osb.density, p1_osb.density, p1_osb.density,
                   p1_osb.density, p1_osb.density};
  assign p2_isb = '{req: p1_osb.req_type, rho: p1_osb.density, sat_t: p1_sat};

  sgpe_div #(
    .LANES(6),
    .SB_W($bits(p2_sb_t))
  ) u_div_first (
    .clk_i,
    .rst_ni,
    .en_i(en),
    .valid_i(p1_v),
    .num_i(p2_num),
    .den_i(p2_den),
    .sb_i(p2_isb),
    .valid_o(p2_v),
    .quo_o(p2_quo),
    .sat_o(p2_sat),
    .sb_o(p2_osb)
  );

  // squared velocities, (gamma-1)*rho and gamma*p0
  assign p3_a = {gam64, gam_m1, p2_quo[2], p2_quo[1], p2_quo[0]};
  assign p3_b = {p064, p2_osb.rho, p2_quo[2], p2_quo[1], p2_quo[0]};
  assign p3_isb = '{req: p2_osb.req, rho: p2_osb.rho, er: p2_quo[3], p0r: p2_quo[4],
                    tcpg: p2_quo[5],
                    sat_c: (|(p2_sat[2:0] & use_dim)) | p2_sat[3] | p2_sat[4],
                    sat_t: p2_osb.sat_t | p2_sat[5]};

  sgpe_mul #(
    .LANES(5),
    .SB_W($bits(p3_sb_t))
  ) u_mul_sq (
    .clk_i,
    .rst_ni,
    .en_i(en),
    .valid_i(p2_v),
    .a_i(p3_a),
    .b_i(p3_b),
    .sb_i(p3_isb),
    .valid_o(p3_v),
    .prod_o(p3_prod),
    .sat_o(p3_sat),
    .sb_o(p3_osb)
  );

  // kinetic energy sum, then energies, then mode select
  always_comb begin
    for (int d = 0; d < sgpe_pkg::MAX_DIMS; d++) begin
      sqm[d] = use_dim[d] ? p3_prod[d] : 64'd0;
    end
    s1r = sat_add(sqm[0], sqm[1]);
    g1_d = '{req: p3_osb.req, rho: p3_osb.rho, er: p3_osb.er, p0r: p3_osb.p0r,
             tcpg: p3_osb.tcpg, grho: p3_prod[3], gp0: p3_prod[4], sq2: sqm[2],
             s1: s1r[63:0],
             sat_c: p3_osb.sat_c | (|(p3_sat[2:0] & use_dim)) | p3_sat[3]
                    | p3_sat[4] | s1r[64],
             sat_t: p3_osb.sat_t};

    kes = sat_add(g1_q.s1, g1_q.sq2);
    ets = sat_add(g1_q.tcpg, g1_q.p0r);
    g2_d = '{req: g1_q.req, rho: g1_q.rho, er: g1_q.er, p0r: g1_q.p0r,
             grho: g1_q.grho, gp0: g1_q.gp0, ke: {kes[63], kes[63:1]},
             et: ets[63:0], sat_c: g1_q.sat_c | kes[64],
             sat_t: g1_q.sat_t | ets[64]};

    eens = sat_sub(g2_q.er, g2_q.ke);
    g3_d = '{req: g2_q.req, rho: g2_q.rho, p0r: g2_q.p0r, grho: g2_q.grho,
             gp0: g2_q.gp0, een: eens[63:0], et: g2_q.et,
             sat_c: g2_q.sat_c | eens[64], sat_t: g2_q.sat_t};

    ds = sat_sub(g3_q.een, g3_q.p0r);
    g4_d = '{rho: g3_q.rho, grho: g3_q.grho, gp0: g3_q.gp0,
             e: (g3_q.req ? g3_q.et : g3_q.een), d: ds[63:0],
             sat: g3_q.sat_c | ds[64] | (g3_q.req & g3_q.sat_t)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q <= 1'b0;
      g2_v_q <= 1'b0;
      g3_v_q <= 1'b0;
      g4_v_q <= 1'b0;
      g5_v_q <= 1'b0;
      g6_v_q <= 1'b0;
    end else if (en) begin
      g1_v_q <= p3_v;
      g2_v_q <= g1_v_q;
      g3_v_q <= g2_v_q;
      g4_v_q <= g3_v_q;
      g5_v_q <= p4_v;
      g6_v_q <= g5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q <= g1_d;
      g2_q <= g2_d;
      g3_q <= g3_d;
      g4_q <= g4_d;
      g5_q <= g5_d;
      g6_q <= g6_d;
    end
  end

  // (gamma-1)*rho*e and temperature numerator times gamma
  assign p4_isb = '{rho: g4_q.rho, gp0: g4_q.gp0, e: g4_q.e, sat: g4_q.sat};

  sgpe_mul #(
    .LANES(2),
    .SB_W($bits(p4_sb_t))
  ) u_mul_press (
    .clk_i,
    .rst_ni,
    .en_i(en),
    .valid_i(g4_v_q),
    .a_i({g4_q.d, g4_q.grho}),
    .b_i({gam64, g4_q.e}),
    .sb_i(p4_isb),
    .valid_o(p4_v),
    .prod_o(p4_prod),
    .sat_o(p4_sat),
    .sb_o(p4_osb)
  );

  // pressure, then pressure plus p0
  always_comb begin
    ps = sat_sub(p4_prod[0], p4_osb.gp0);
    g5_d = '{rho: p4_osb.rho, e: p4_osb.e, p: ps[63:0], tm: p4_prod[1],
             sat: p4_osb.sat | (|p4_sat) | ps[64]};
    sps = sat_add(g5_q.p, p064);
    g6_d = '{rho: g5_q.rho, e: g5_q.e, p: g5_q.p, sp: sps[63:0], tm: g5_q.tm,
             sat: g5_q.sat | sps[64]};
  end

  // gamma*(p+p0)
  assign p5_isb = '{rho: g6_q.rho, e: g6_q.e, p: g6_q.p, tm: g6_q.tm, sat: g6_q.sat};

  sgpe_mul #(
    .LANES(1),
    .SB_W($bits(g5_t))
  ) u_mul_root (
    .clk_i,
    .rst_ni,
    .en_i(en),
    .valid_i(g6_v_q),
    .a_i(gam64),
    .b_i(g6_q.sp),
    .sb_i(p5_isb),
    .valid_o(p5_v),
    .prod_o(p5_prod),
    .sat_o(p5_sat),
    .sb_o(p5_osb)
  );

  // p/rho, root argument and temperature
  assign p6_num = {p5_osb.tm, p5_prod, p5_osb.p};
  assign p6_den = {cp64, p5_osb.rho, p5_osb.rho};
  assign p6_isb = '{rho: p5_osb.rho, e: p5_osb.e, p: p5_osb.p,
                    sat: p5_osb.sat | p5_sat};

  sgpe_div #(
    .LANES(3),
    .SB_W($bits(p6_sb_t))
  ) u_div_second (
    .clk_i,
    .rst_ni,
    .en_i(en),
    .valid_i(p5_v),
    .num_i(p6_num),
    .den_i(p6_den),
    .sb_i(p6_isb),
    .valid_o(p6_v),
    .quo_o(p6_quo),
    .sat_o(p6_sat),
    .sb_o(p6_osb)
  );

  // enthalpy and root argument sign
  always_comb begin
    enths = sat_add(p6_osb.e, p6_quo[0]);
    g7_d = '{rho: p6_osb.rho, e: p6_osb.e, p: p6_osb.p, temp: p6_quo[2],
             enth: enths[63:0], neg: p6_quo[1][63],
             sat: p6_osb.sat | (|p6_sat) | enths[64]};
  end

  // square root pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_v_q <= '0;
    end else if (en) begin
      sr_v_q <= {sr_v_q[SqSteps-1:0], p6_v};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_rem_q[0] <= '0;
      sr_root_q[0] <= '0;
      sr_rad_q[0] <= p6_quo[1][63] ? 88'd0 : {p6_quo[1], 24'd0};
      sr_sb_q[0] <= g7_d;
      for (int s = 1; s <= SqSteps; s++) begin
        {sr_rem_q[s], sr_root_q[s], sr_rad_q[s]} <= sqrt_step(sr_rem_q[s-1],
                                                              sr_root_q[s-1],
                                                              sr_rad_q[s-1]);
        sr_sb_q[s] <= sr_sb_q[s-1];
      end
    end
  end

  // result assembly and status
  always_comb begin
    last = sr_sb_q[SqSteps];
    if (last.rho[63] || (last.rho == 64'd0)) begin
      pipe_item = '0;
      pipe_item.status = sgpe_pkg::ST_BAD_DENSITY;
    end else begin
      pipe_item.pressure = last.p;
      pipe_item.temperature_out = last.temp;
      pipe_item.internal_energy = last.e;
      pipe_item.enthalpy = last.enth;
      pipe_item.sound_speed = last.neg ? 63'd0 : {19'd0, sr_root_q[SqSteps]};
      pipe_item.status = last.neg ? sgpe_pkg::ST_NEG_ROOT :
                         (last.sat ? sgpe_pkg::ST_SAT : sgpe_pkg::ST_OK);
    end
  end

  // output register with skid stage
  assign take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) skid_v_q <= 1'b0;
    end else if (sr_v_q[SqSteps]) begin
      if (!out_v_q || take) out_v_q <= 1'b1;
      else skid_v_q <= 1'b1;
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) out_q <= skid_q;
    end else if (sr_v_q[SqSteps]) begin
      if (!out_v_q || take) out_q <= pipe_item;
      else skid_q <= pipe_item;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o = out_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds an item while output is empty");

  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_stall_i |=> skid_v_q)
    else $error("skid item lost while output stalled");

  a_bad_density_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.status == sgpe_pkg::ST_BAD_DENSITY) |->
    (out_q.pressure == '0) && (out_q.enthalpy == '0) && (out_q.sound_speed == '0))
    else $error("non-positive density item carries non-zero fields");

  a_neg_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.status == sgpe_pkg::ST_NEG_ROOT) |-> (out_q.sound_speed == '0))
    else $error("negative root argument with non-zero sound speed");
`endif

endmodule

// ===== test/stiffened_gas_property_eval_checker.sv =====
// stiffened_gas_property_eval_checker: watches the cell and result channels and the
// register port, predicts each result from its own copy of the registers and compares.
// Depends on sgpe_pkg for the item types, register indexes and status codes.
module stiffened_gas_property_eval_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  sgpe_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  sgpe_pkg::out_item_t out_item_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [58:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [63:0] S_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;

  // register copy
  logic [39:0] gamma_q;
  logic [39:0] cp_q;
  logic [58:0] p0_q;
  logic [1:0]  dims_q;

  // set by any saturating step of the current cell
  bit                  clipped;
  sgpe_pkg::out_item_t cell_results_q[$];
  int                  fail_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = cell_results_q.size();

  function automatic logic [63:0] abs64(logic signed [63:0] a);
    return a < 0 ? 64'd0 - a : a;
  endfunction

  // sign a wide magnitude and clip to the 64-bit range
  function automatic logic signed [63:0] clip_signed(bit neg, logic [127:0] mag);
    if (neg) begin
      if (mag > 128'h8000_0000_0000_0000) begin
        clipped = 1;
        return S_MIN;
      end
      return 64'd0 - mag[63:0];
    end
    if (mag > 128'h7fff_ffff_ffff_ffff) begin
      clipped = 1;
      return S_MAX;
    end
    return mag[63:0];
  endfunction

  function automatic logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    return clip_signed((a < 0) != (b < 0), prod >> sgpe_pkg::FRAC_BITS);
  endfunction

  function automatic logic signed [63:0] q_div(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] num;
    if (b == 0) begin
      clipped = 1;
      return a > 0 ? S_MAX : (a < 0 ? S_MIN : 64'sd0);
    end
    num = {64'd0, abs64(a)} << sgpe_pkg::FRAC_BITS;
    return clip_signed((a < 0) != (b < 0), num / {64'd0, abs64(b)});
  endfunction

  function automatic logic signed [63:0] q_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(S_MAX)) begin
      clipped = 1;
      return S_MAX;
    end
    if (s < 65'(S_MIN)) begin
      clipped = 1;
      return S_MIN;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] q_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(S_MAX)) begin
      clipped = 1;
      return S_MAX;
    end
    if (s < 65'(S_MIN)) begin
      clipped = 1;
      return S_MIN;
    end
    return s[63:0];
  endfunction

  // floor(sqrt(arg * 2^24)), bit by bit from the top
  function automatic logic [63:0] q_root(logic signed [63:0] arg);
    logic [127:0] target;
    logic [127:0] root;
    logic [127:0] trial;
    target = {64'd0, arg} << sgpe_pkg::FRAC_BITS;
    root = '0;
    for (int b = sgpe_pkg::SQRT_STEPS - 1; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= target) root = trial;
    end
    return root[63:0];
  endfunction

  // stiffened-gas properties of one cell
  function automatic sgpe_pkg::out_item_t gas_properties(sgpe_pkg::in_item_t c);
    sgpe_pkg::out_item_t r;
    logic signed [63:0] rho, gam, cp, p0, ke, u, e_en, e, p, p0_rho, arg;
    logic signed [63:0] mom[3];
    int n;
    r = '0;
    clipped = 0;
    rho = c.density;
    if (rho <= 0) begin
      r.status = sgpe_pkg::ST_BAD_DENSITY;
      return r;
    end
    gam = {24'd0, gamma_q};
    cp  = {24'd0, cp_q};
    p0  = {5'd0, p0_q};
    mom[0] = c.momentum_x;
    mom[1] = c.momentum_y;
    mom[2] = c.momentum_z;
    n = dims_q > sgpe_pkg::MAX_DIMS ? sgpe_pkg::MAX_DIMS : dims_q;
    ke = '0;
    for (int d = 0; d < n; d++) begin
      u  = q_div(mom[d], rho);
      ke = q_add(ke, q_mul(u, u));
    end
    // kinetic sum is never negative, so halving is a plain shift
    ke = ke >>> 1;
    e_en   = q_sub(q_div(c.energy_density, rho), ke);
    p0_rho = q_div(p0, rho);
    if (c.req_type) e = q_add(q_div(q_mul(c.temperature_in, cp), gam), p0_rho);
    else e = e_en;
    p = q_sub(q_mul(q_mul(gam - 64'sh100_0000, rho), e), q_mul(gam, p0));
    r.pressure        = p;
    r.temperature_out = q_div(q_mul(q_sub(e_en, p0_rho), gam), cp);
    r.internal_energy = e;
    r.enthalpy        = q_add(e, q_div(p, rho));
    arg = q_div(q_mul(gam, q_add(p, p0)), rho);
    if (arg < 0) r.status = sgpe_pkg::ST_NEG_ROOT;
    else begin
      r.sound_speed = 63'(q_root(arg));
      r.status = clipped ? sgpe_pkg::ST_SAT : sgpe_pkg::ST_OK;
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    fail_count++;
    if (fail_count <= 60)
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // register writes, cell acceptance and result comparison
  always @(posedge clk_i or negedge rst_ni) begin
    sgpe_pkg::out_item_t want;
    if (!rst_ni) begin
      gamma_q = 40'd32413581;
      cp_q    = 40'd135812905697;
      p0_q    = 59'd19537068032000000;
      dims_q  = 2'd3;
      cell_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sgpe_pkg::CFG_GAMMA: gamma_q = cfg_data_i[39:0];
          sgpe_pkg::CFG_CP:    cp_q    = cfg_data_i[39:0];
          sgpe_pkg::CFG_P0:    p0_q    = cfg_data_i;
          sgpe_pkg::CFG_DIMS:  dims_q  = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) cell_results_q.push_back(gas_properties(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (cell_results_q.size() == 0) report("unexpected item", 64'd0, 64'd0);
        else begin
          want = cell_results_q.pop_front();
          if (out_item_i.pressure != want.pressure)
            report("pressure", out_item_i.pressure, want.pressure);
          if (out_item_i.temperature_out != want.temperature_out)
            report("temperature_out", out_item_i.temperature_out, want.temperature_out);
          if (out_item_i.internal_energy != want.internal_energy)
            report("internal_energy", out_item_i.internal_energy, want.internal_energy);
          if (out_item_i.enthalpy != want.enthalpy)
            report("enthalpy", out_item_i.enthalpy, want.enthalpy);
          if (out_item_i.sound_speed != want.sound_speed)
            report("sound_speed", {1'b0, out_item_i.sound_speed}, {1'b0, want.sound_speed});
          if (out_item_i.status != want.status)
            report("status", {62'd0, out_item_i.status}, {62'd0, want.status});
        end
      end
    end
  end

endmodule

// ===== test/stiffened_gas_property_eval_top_tb.sv =====
// stiffened_gas_property_eval_top_tb: drives cells and register writes into the
// property evaluator, stalls its output and gives the verdict.
// Depends on sgpe_pkg, the RTL top and stiffened_gas_property_eval_checker.
module stiffened_gas_property_eval_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_CELLS = 1750;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic signed [63:0] ONE = 64'sh100_0000;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                in_valid_i = 0;
  logic                in_stall_o;
  sgpe_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 0;
  sgpe_pkg::out_item_t out_item_o;
  logic                cfg_we_i = 0;
  logic [1:0]          cfg_idx_i = sgpe_pkg::CFG_GAMMA;
  logic [58:0]         cfg_data_i = '0;
  int                  fail_count;
  int                  pending;
  int                  cycles = 0;
  bit                  sending_done = 0;

  always #2 clk_i = ~clk_i;

  stiffened_gas_property_eval_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  stiffened_gas_property_eval_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall pattern, one long hold-off early on
  initial begin
    int mode;
    repeat (40) @(posedge clk_i);
    out_stall_i <= 1;
    repeat (600) @(posedge clk_i);
    while (!sending_done) begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 30)) begin
        out_stall_i <= (mode == 0) ? 1'b0 : (mode == 1) ? 1'b1 : ($urandom_range(0, 2) == 0);
        @(posedge clk_i);
      end
    end
    out_stall_i <= 0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // a physically plausible cell with random content
  function automatic sgpe_pkg::in_item_t plausible_cell();
    sgpe_pkg::in_item_t c;
    c.req_type       = 1'($urandom_range(0, 1));
    c.density        = 64'($urandom_range(1, 1 << 20)) << $urandom_range(0, 14);
    c.momentum_x     = 64'(signed'($urandom)) <<< $urandom_range(0, 12);
    c.momentum_y     = 64'(signed'($urandom)) <<< $urandom_range(0, 12);
    c.momentum_z     = 64'(signed'($urandom)) <<< $urandom_range(0, 12);
    c.energy_density = {32'($urandom_range(0, 32'h3fff_ffff)), $urandom};
    c.temperature_in = 64'($urandom_range(0, 32'hffff_ffff)) << $urandom_range(0, 12);
    if ($urandom_range(0, 9) == 0) c.temperature_in = -c.temperature_in;
    return c;
  endfunction

  function automatic sgpe_pkg::in_item_t noise_cell();
    sgpe_pkg::in_item_t c;
    c.req_type = 1'($urandom_range(0, 1));
    c.density = rand64();
    c.momentum_x = rand64();
    c.momentum_y = rand64();
    c.momentum_z = rand64();
    c.energy_density = rand64();
    c.temperature_in = rand64();
    return c;
  endfunction

  task automatic send_cell(sgpe_pkg::in_item_t c);
    in_valid_i <= 1;
    in_item_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // write enable is dropped by the caller after the last write
  task automatic write_reg(logic [1:0] idx, logic [58:0] data);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // every result back before a register changes
  task automatic drain();
    pause(1);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_gas(logic [39:0] g, logic [39:0] cp, logic [58:0] p0, logic [1:0] d);
    drain();
    write_reg(sgpe_pkg::CFG_GAMMA, 59'(g));
    write_reg(sgpe_pkg::CFG_CP, 59'(cp));
    write_reg(sgpe_pkg::CFG_P0, p0);
    write_reg(sgpe_pkg::CFG_DIMS, 59'(d));
    cfg_we_i <= 0;
  endtask

  task automatic random_burst(int count);
    int left;
    left = count;
    while (left > 0) begin
      repeat ($urandom_range(1, 40)) begin
        if (left > 0) begin
          send_cell(($urandom_range(0, 7) == 0) ? noise_cell() : plausible_cell());
          left--;
        end
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
    end
  endtask

  initial begin
    sgpe_pkg::in_item_t c;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: field extremes, both modes, bad density, clipping
    c = plausible_cell();
    c.req_type = 1'b0; send_cell(c);
    c.req_type = 1'b1; send_cell(c);
    c.density = '0; send_cell(c);
    c.density = -ONE; send_cell(c);
    c.density = 64'sh8000_0000_0000_0000; send_cell(c);
    c.density = 64'sh7fff_ffff_ffff_ffff; send_cell(c);
    c = plausible_cell(); c.density = 64'sd1; send_cell(c);
    c.momentum_x = 64'sh7fff_ffff_ffff_ffff; c.momentum_y = 64'sh8000_0000_0000_0000;
    send_cell(c);
    c = plausible_cell(); c.energy_density = 64'sh8000_0000_0000_0000; send_cell(c);
    c.energy_density = 64'sh7fff_ffff_ffff_ffff; c.req_type = 1'b1;
    c.temperature_in = 64'sh7fff_ffff_ffff_ffff; send_cell(c);
    c.temperature_in = 64'sh8000_0000_0000_0000; send_cell(c);
    c = '1; c.density = ONE; send_cell(c);
    c = '0; c.density = ONE; send_cell(c);
    random_burst(300);

    // zero gamma and Cp as divisors, no momentum used
    set_gas(40'd0, 40'd0, 59'd0, 2'd0);
    c = plausible_cell(); c.req_type = 1'b1; send_cell(c);
    c.req_type = 1'b0; send_cell(c);
    c.temperature_in = '0; c.energy_density = '0; c.req_type = 1'b1; send_cell(c);
    random_burst(150);

    // largest gamma and Cp, large p0, one dimension
    set_gas(40'hff_ffff_ffff, 40'hff_ffff_ffff, 59'd549755813887999999, 2'd1);
    random_burst(300);

    // light ideal-like gas, two dimensions
    set_gas(40'd23488102, 40'd16777216, 59'd0, 2'd2);
    random_burst(400);

    // random settings
    set_gas({8'($urandom_range(0, 255)), $urandom}, {8'($urandom_range(0, 255)), $urandom},
            59'($urandom) << $urandom_range(0, 24), 2'($urandom_range(0, 3)));
    random_burst(300);

    set_gas(40'd32413581, 40'd135812905697, 59'd19537068032000000, 2'd3);
    random_burst(300);

    pause(1);
    sending_done = 1;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sgpe_pkg.sv
sv/sgpe_mul.sv
sv/sgpe_div.sv
sv/stiffened_gas_property_eval_top.sv
test/stiffened_gas_property_eval_checker.sv
test/stiffened_gas_property_eval_top_tb.sv
